>>> hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

    // Width of the phase timer; durations above its maximum saturate
    localparam int TIMER_BITS = 16;
    localparam logic [TIMER_BITS-1:0] TICK_MAX = '1;

    typedef logic [TIMER_BITS-1:0] t_ticks;

    // Request type codes on the input channel (code 3 is reserved)
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_BYTE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOW  = 2'd0;
    localparam logic [1:0] CFG_HIGH = 2'd1;
    localparam logic [1:0] CFG_ACK  = 2'd2;

    // Register reset values
    localparam logic [15:0] RST_LOW  = 16'd2;
    localparam logic [15:0] RST_HIGH = 16'd5;
    localparam logic [15:0] RST_ACK  = 16'd1000;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_BYTE,
        CMD_NONE
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ADDR_NACK    = 3'd1,
        ST_REG_NACK     = 3'd2,
        ST_DATA_NACK    = 3'd3,
        ST_RD_ADDR_NACK = 3'd4
    } t_status;

    typedef struct packed {
        logic        we;
        logic [1:0]  idx;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_cmd_kind   kind;
        logic        sda;
        logic        read_mode;
        logic [6:0]  target_addr;
        logic [7:0]  reg_addr;
        logic [7:0]  byte_count;
        logic [7:0]  data_byte;
    } t_cmd;

    // Clamp a tick count: zero acts as one, large counts saturate
    function automatic t_ticks f_span(input logic [15:0] v);
        logic [63:0] w;
        w = 64'(v);
        if (w == 64'd0) w = 64'd1;
        if (w > 64'(TICK_MAX)) w = 64'(TICK_MAX);
        return w[TIMER_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/i2cm_ifs.sv
// Request channel into the controller
interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       sda_in;
    logic       read_mode;
    logic [6:0] target_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;

    modport source (
        output valid, req_type, sda_in, read_mode, target_addr, reg_addr, byte_count,
               data_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, sda_in, read_mode, target_addr, reg_addr, byte_count,
               data_byte,
        output ready
    );
endinterface

// Result channel out of the controller
interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       need_byte;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    logic [2:0] status;

    modport source (
        output valid, scl_level, sda_level, busy_res, need_byte, rx_data, rx_valid,
               rx_last, done_res, status,
        input  ready
    );
    modport sink (
        input  valid, scl_level, sda_level, busy_res, need_byte, rx_data, rx_valid,
               rx_last, done_res, status,
        output ready
    );
endinterface

>>> hw/rtl/i2cm_front.sv
module i2cm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    i2cm_req_if.sink        i_req,
    output logic            o_cmd_valid,
    output i2cm_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_pop
);
    import i2cm_pkg::*;

    t_cmd       w_cmd;
    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    // Classify the request and normalize its fields
    always_comb begin
        w_cmd.sda         = i_req.sda_in;
        w_cmd.read_mode   = i_req.read_mode;
        w_cmd.target_addr = i_req.target_addr;
        w_cmd.reg_addr    = i_req.reg_addr;
        w_cmd.byte_count  = (i_req.byte_count == 8'd0) ? 8'd1 : i_req.byte_count;
        w_cmd.data_byte   = i_req.data_byte;
        unique case (i_req.req_type)
            REQ_TICK:  w_cmd.kind = CMD_TICK;
            REQ_START: w_cmd.kind = CMD_START;
            REQ_BYTE:  w_cmd.kind = CMD_BYTE;
            default:   w_cmd.kind = CMD_NONE;
        endcase
    end

    assign i_req.ready = (r_count != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_cmd_pop && (r_count != 2'd0);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Hold queued requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (w_push && !w_pop) r_count <= r_count + 2'd1;
            else if (w_pop && !w_push) r_count <= r_count - 2'd1;
        end
    end

endmodule

>>> hw/rtl/i2cm_engine.sv
module i2cm_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  i2cm_pkg::t_cfg_wr i_cfg,
    input  logic              i_cmd_valid,
    input  i2cm_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    i2cm_res_if.source        o_res
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_STA_A, PH_STA_B, PH_STA_C, PH_RS_LOW, PH_BIT_SET, PH_BIT_HIGH,
        PH_BIT_HOLD, PH_ACK_LOW, PH_ACK_HIGH, PH_ACK_WAIT, PH_ACK_TAIL, PH_NEED,
        PH_RD_LOW, PH_RD_HIGH, PH_MA_SET, PH_MA_HIGH, PH_MA_HOLD,
        PH_STP_A, PH_STP_B, PH_STP_C, PH_STP_D
    } t_phase;

    typedef enum logic [1:0] {
        STG_ADDR_W, STG_REG, STG_DATA, STG_ADDR_R
    } t_stage;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       need_byte;
        logic [7:0] rx_data;
        logic       rx_valid;
        logic       rx_last;
        logic       done_res;
        t_status    status;
    } t_res;

    t_ticks     r_low, r_high, r_ack;
    t_phase     r_phase, n_phase;
    t_ticks     r_timer, n_timer;
    logic [2:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [6:0] r_dev, n_dev;
    logic [7:0] r_reg, n_reg;
    logic       r_rd_mode, n_rd_mode;
    logic       r_pend_valid, n_pend_valid;
    logic [7:0] r_pend_data, n_pend_data;
    t_stage     r_stage, n_stage;
    t_status    r_end_code, n_end_code;
    logic       r_out_valid;
    t_res       r_out, n_out;

    logic       w_step;
    t_ticks     w_inc;
    t_ticks     w_len;
    logic       w_expire;
    logic [7:0] w_rd_shift;

    assign w_step    = i_cmd_valid && (!r_out_valid || o_res.ready);
    assign o_cmd_pop = w_step;

    // Pick the length of the current phase and step the shared timer
    always_comb begin
        unique case (r_phase)
            PH_STA_A, PH_STA_B, PH_BIT_HIGH, PH_ACK_HIGH, PH_RD_HIGH, PH_MA_HIGH,
            PH_STP_C, PH_STP_D: w_len = r_high;
            PH_ACK_WAIT:        w_len = r_ack;
            default:            w_len = r_low;
        endcase
        w_inc    = (r_timer == TICK_MAX) ? r_timer : r_timer + 1'b1;
        w_expire = (w_inc >= w_len);
    end

    assign w_rd_shift = {r_shift[6:0], i_cmd.sda};

    // Bus sequencer: next state for one request
    always_comb begin
        n_phase      = r_phase;
        n_timer      = r_timer;
        n_bit_idx    = r_bit_idx;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_dev        = r_dev;
        n_reg        = r_reg;
        n_rd_mode    = r_rd_mode;
        n_pend_valid = r_pend_valid;
        n_pend_data  = r_pend_data;
        n_stage      = r_stage;
        n_end_code   = r_end_code;
        n_out        = '0;

        unique case (i_cmd.kind)
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    n_rd_mode    = i_cmd.read_mode;
                    n_dev        = i_cmd.target_addr;
                    n_reg        = i_cmd.reg_addr;
                    n_bytes_left = i_cmd.byte_count;
                    n_pend_valid = 1'b0;
                    n_bit_idx    = '0;
                    n_end_code   = ST_OK;
                    n_stage      = STG_ADDR_W;
                    n_phase      = PH_STA_A;
                    n_timer      = '0;
                end
            end
            CMD_BYTE: begin
                n_pend_valid = 1'b1;
                n_pend_data  = i_cmd.data_byte;
            end
            CMD_TICK: begin
                // Timed phases restart the timer on expiry, which always moves on
                n_timer = w_expire ? '0 : w_inc;
                unique case (r_phase)
                    PH_STA_A: if (w_expire) n_phase = PH_STA_B;
                    PH_STA_B: if (w_expire) n_phase = PH_STA_C;
                    PH_STA_C: begin
                        if (w_expire) begin
                            n_shift   = {r_dev, (r_stage == STG_ADDR_R)};
                            n_bit_idx = '0;
                            n_phase   = PH_BIT_SET;
                        end
                    end
                    PH_RS_LOW:   if (w_expire) n_phase = PH_STA_A;
                    PH_BIT_SET:  if (w_expire) n_phase = PH_BIT_HIGH;
                    PH_BIT_HIGH: if (w_expire) n_phase = PH_BIT_HOLD;
                    PH_BIT_HOLD: begin
                        if (w_expire) begin
                            n_shift = {r_shift[6:0], 1'b0};
                            if (r_bit_idx == 3'd7) begin
                                n_bit_idx = '0;
                                n_phase   = PH_ACK_LOW;
                            end else begin
                                n_bit_idx = r_bit_idx + 3'd1;
                                n_phase   = PH_BIT_SET;
                            end
                        end
                    end
                    PH_ACK_LOW:  if (w_expire) n_phase = PH_ACK_HIGH;
                    PH_ACK_HIGH: if (w_expire) n_phase = PH_ACK_WAIT;
                    PH_ACK_WAIT: begin
                        if (!i_cmd.sda) begin
                            n_timer = '0;
                            n_phase = PH_ACK_TAIL;
                        end else if (w_expire) begin
                            unique case (r_stage)
                                STG_ADDR_W: n_end_code = ST_ADDR_NACK;
                                STG_REG:    n_end_code = ST_REG_NACK;
                                STG_DATA:   n_end_code = ST_DATA_NACK;
                                default:    n_end_code = ST_RD_ADDR_NACK;
                            endcase
                            n_phase = PH_STP_A;
                        end
                    end
                    PH_ACK_TAIL: begin
                        if (w_expire) begin
                            unique case (r_stage)
                                STG_ADDR_W: begin
                                    n_stage = STG_REG;
                                    n_shift = r_reg;
                                    n_phase = PH_BIT_SET;
                                end
                                STG_REG: begin
                                    if (r_rd_mode) begin
                                        n_stage = STG_ADDR_R;
                                        n_phase = PH_RS_LOW;
                                    end else begin
                                        n_stage = STG_DATA;
                                        n_phase = PH_NEED;
                                    end
                                end
                                STG_DATA: begin
                                    n_bytes_left = r_bytes_left - 8'd1;
                                    if (r_bytes_left == 8'd1) begin
                                        n_end_code = ST_OK;
                                        n_phase    = PH_STP_A;
                                    end else begin
                                        n_phase = PH_NEED;
                                    end
                                end
                                default: begin
                                    n_shift   = '0;
                                    n_bit_idx = '0;
                                    n_phase   = PH_RD_LOW;
                                end
                            endcase
                        end
                    end
                    PH_NEED: begin
                        n_timer = r_timer;
                        if (r_pend_valid) begin
                            n_shift      = r_pend_data;
                            n_pend_valid = 1'b0;
                            n_bit_idx    = '0;
                            n_timer      = '0;
                            n_phase      = PH_BIT_SET;
                        end
                    end
                    PH_RD_LOW: if (w_expire) n_phase = PH_RD_HIGH;
                    PH_RD_HIGH: begin
                        if (w_expire) begin
                            n_shift = w_rd_shift;
                            if (r_bit_idx == 3'd7) begin
                                n_bit_idx      = '0;
                                n_out.rx_valid = 1'b1;
                                n_out.rx_data  = w_rd_shift;
                                n_out.rx_last  = (r_bytes_left <= 8'd1);
                                n_phase        = PH_MA_SET;
                            end else begin
                                n_bit_idx = r_bit_idx + 3'd1;
                                n_phase   = PH_RD_LOW;
                            end
                        end
                    end
                    PH_MA_SET:  if (w_expire) n_phase = PH_MA_HIGH;
                    PH_MA_HIGH: if (w_expire) n_phase = PH_MA_HOLD;
                    PH_MA_HOLD: begin
                        if (w_expire) begin
                            if (r_bytes_left <= 8'd1) begin
                                n_bytes_left = '0;
                                n_end_code   = ST_OK;
                                n_phase      = PH_STP_A;
                            end else begin
                                n_bytes_left = r_bytes_left - 8'd1;
                                n_shift      = '0;
                                n_phase      = PH_RD_LOW;
                            end
                        end
                    end
                    PH_STP_A: if (w_expire) n_phase = PH_STP_B;
                    PH_STP_B: if (w_expire) n_phase = PH_STP_C;
                    PH_STP_C: if (w_expire) n_phase = PH_STP_D;
                    PH_STP_D: begin
                        if (w_expire) begin
                            n_out.done_res = 1'b1;
                            n_out.status   = r_end_code;
                            n_end_code     = ST_OK;
                            n_phase        = PH_IDLE;
                        end
                    end
                    default: begin
                        n_timer = '0;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            default: ;
        endcase

        // Drive levels follow the phase that the request leaves behind
        unique case (n_phase)
            PH_IDLE, PH_STA_A, PH_ACK_HIGH, PH_ACK_WAIT, PH_RD_HIGH, PH_STP_D: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b1;
            end
            PH_STA_B, PH_STP_C: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = 1'b0;
            end
            PH_STA_C, PH_STP_B: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = 1'b0;
            end
            PH_BIT_SET, PH_BIT_HOLD: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = n_shift[7];
            end
            PH_BIT_HIGH: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = n_shift[7];
            end
            PH_MA_SET, PH_MA_HOLD: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = (n_bytes_left <= 8'd1);
            end
            PH_MA_HIGH: begin
                n_out.scl_level = 1'b1;
                n_out.sda_level = (n_bytes_left <= 8'd1);
            end
            default: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = 1'b1;
            end
        endcase
        n_out.busy_res  = (n_phase != PH_IDLE);
        n_out.need_byte = (n_phase == PH_NEED) && !n_pend_valid;
    end

    // Hold state, configuration and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low        <= f_span(RST_LOW);
            r_high       <= f_span(RST_HIGH);
            r_ack        <= f_span(RST_ACK);
            r_phase      <= PH_IDLE;
            r_timer      <= '0;
            r_bit_idx    <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
            r_dev        <= '0;
            r_reg        <= '0;
            r_rd_mode    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_data  <= '0;
            r_stage      <= STG_ADDR_W;
            r_end_code   <= ST_OK;
            r_out_valid  <= 1'b0;
            r_out        <= '0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_LOW:  r_low  <= f_span({8'd0, i_cfg.data[7:0]});
                    CFG_HIGH: r_high <= f_span({8'd0, i_cfg.data[7:0]});
                    CFG_ACK:  r_ack  <= f_span(i_cfg.data);
                    default: ;
                endcase
            end
            if (w_step) begin
                r_phase      <= n_phase;
                r_timer      <= n_timer;
                r_bit_idx    <= n_bit_idx;
                r_shift      <= n_shift;
                r_bytes_left <= n_bytes_left;
                r_dev        <= n_dev;
                r_reg        <= n_reg;
                r_rd_mode    <= n_rd_mode;
                r_pend_valid <= n_pend_valid;
                r_pend_data  <= n_pend_data;
                r_stage      <= n_stage;
                r_end_code   <= n_end_code;
                r_out        <= n_out;
                r_out_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_out.scl_level;
    assign o_res.sda_level = r_out.sda_level;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.need_byte = r_out.need_byte;
    assign o_res.rx_data   = r_out.rx_data;
    assign o_res.rx_valid  = r_out.rx_valid;
    assign o_res.rx_last   = r_out.rx_last;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.status    = r_out.status;

endmodule

>>> hw/rtl/i2c_master_register_access_core.sv
// I2C master for 7-bit addressed register access. Every request (a timing
// tick carrying the sampled SDA level, a transaction start, a write data
// byte or a reserved code) yields exactly one result with the SCL/SDA drive
// levels, busy and need-byte flags, any received byte and the
// end-of-transaction status. The block takes one request per clock,
// sustained, as long as results are taken; a request's result passes
// through the two-entry request queue and then the result register before
// it can be taken. The one-request-per-clock rate is set by the bus
// sequencer, which updates its whole state once per request. Configuration
// may be written only while the block is idle.
module i2c_master_register_access_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    i2cm_req_if.sink    i_req,
    i2cm_res_if.source  o_res
);
    import i2cm_pkg::*;

    t_cfg_wr w_cfg;
    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    // Accept and classify requests
    i2cm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Run the bus sequence
    i2cm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (o_res)
    );

    // A received byte and the end of a transaction never share a result
    a_rx_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.rx_valid && o_res.done_res))
        else $error("received byte reported together with transaction end");

    // An error code is only reported with the end of a transaction
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.done_res) |-> (o_res.status == ST_OK))
        else $error("status code without transaction end");

    // Transaction end leaves the bus released and the block idle
    a_done_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.done_res) |->
            (!o_res.busy_res && o_res.scl_level && o_res.sda_level))
        else $error("bus not released at transaction end");

    // Waiting for a write byte holds SCL low inside a transaction
    a_need_scl_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.need_byte) |-> (!o_res.scl_level && o_res.busy_res))
        else $error("write byte wait without SCL held low");

endmodule

>>> sim/tb.sv
import i2cm_pkg::*;

// Bus sequencer phases as the predictor tracks them
typedef enum logic [4:0] {
    BP_IDLE,
    BP_START_HI,
    BP_START_SDA,
    BP_START_SCL,
    BP_RESTART,
    BP_BIT_SETUP,
    BP_BIT_HIGH,
    BP_BIT_HOLD,
    BP_ACK_LOW,
    BP_ACK_HIGH,
    BP_ACK_WAIT,
    BP_ACK_TAIL,
    BP_WAIT_BYTE,
    BP_RD_LOW,
    BP_RD_HIGH,
    BP_MACK_SETUP,
    BP_MACK_HIGH,
    BP_MACK_HOLD,
    BP_STOP_A,
    BP_STOP_B,
    BP_STOP_C,
    BP_STOP_D
} t_bus_phase;

// Which byte of the transaction is on the wire
typedef enum logic [1:0] {
    SG_ADDR_W,
    SG_REG,
    SG_DATA,
    SG_ADDR_R
} t_byte_stage;

typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       need_byte;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_last;
    logic       done;
    logic [2:0] status;
} t_line_result;

// Tracks the bus sequencer and queues the line levels each request should produce
class i2c_line_predictor;
    logic [15:0]  low_ticks;
    logic [15:0]  high_ticks;
    logic [15:0]  ack_ticks;
    t_bus_phase   phase;
    t_ticks       timer;
    int unsigned  bit_idx;
    logic [7:0]   shifter;
    logic [7:0]   bytes_left;
    logic [6:0]   dev;
    logic [7:0]   reg_sel;
    logic         rd_mode;
    logic         hold_valid;
    logic [7:0]   hold_byte;
    t_byte_stage  stage;
    t_status      end_code;
    t_line_result expected_lines[$];
    int unsigned  failures;

    function new();
        low_ticks  = RST_LOW;
        high_ticks = RST_HIGH;
        ack_ticks  = RST_ACK;
        phase      = BP_IDLE;
        timer      = '0;
        bit_idx    = 0;
        shifter    = '0;
        bytes_left = '0;
        dev        = '0;
        reg_sel    = '0;
        rd_mode    = 1'b0;
        hold_valid = 1'b0;
        hold_byte  = '0;
        stage      = SG_ADDR_W;
        end_code   = ST_OK;
        failures   = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] data);
        case (idx)
            CFG_LOW:  low_ticks  = {8'd0, data[7:0]};
            CFG_HIGH: high_ticks = {8'd0, data[7:0]};
            CFG_ACK:  ack_ticks  = data;
            default: ;
        endcase
    endfunction

    // Advance the phase timer; true once the phase has lasted its length
    function bit elapsed(logic [15:0] len);
        t_ticks lim;
        lim = (len == 16'd0) ? t_ticks'(1) : t_ticks'(len);
        if (timer != TICK_MAX) timer++;
        if (timer >= lim) begin
            timer = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void go(t_bus_phase p);
        phase = p;
        timer = '0;
    endfunction

    function void begin_stop(t_status code);
        end_code = code;
        go(BP_STOP_A);
    endfunction

    function t_status nack_code(t_byte_stage s);
        case (s)
            SG_ADDR_W: return ST_ADDR_NACK;
            SG_REG:    return ST_REG_NACK;
            SG_DATA:   return ST_DATA_NACK;
            default:   return ST_RD_ADDR_NACK;
        endcase
    endfunction

    // One timing tick of the sequencer
    function void tick(logic sda, inout t_line_result r);
        case (phase)
            BP_START_HI:  if (elapsed(high_ticks)) go(BP_START_SDA);
            BP_START_SDA: if (elapsed(high_ticks)) go(BP_START_SCL);
            BP_START_SCL: if (elapsed(low_ticks)) begin
                shifter = {dev, stage == SG_ADDR_R};
                bit_idx = 0;
                go(BP_BIT_SETUP);
            end
            BP_RESTART:   if (elapsed(low_ticks)) go(BP_START_HI);
            BP_BIT_SETUP: if (elapsed(low_ticks)) go(BP_BIT_HIGH);
            BP_BIT_HIGH:  if (elapsed(high_ticks)) go(BP_BIT_HOLD);
            BP_BIT_HOLD:  if (elapsed(low_ticks)) begin
                shifter = shifter << 1;
                bit_idx++;
                if (bit_idx >= 8) begin
                    bit_idx = 0;
                    go(BP_ACK_LOW);
                end else begin
                    go(BP_BIT_SETUP);
                end
            end
            BP_ACK_LOW:   if (elapsed(low_ticks)) go(BP_ACK_HIGH);
            BP_ACK_HIGH:  if (elapsed(high_ticks)) go(BP_ACK_WAIT);
            BP_ACK_WAIT: begin
                if (!sda) go(BP_ACK_TAIL);
                else if (elapsed(ack_ticks)) begin_stop(nack_code(stage));
            end
            BP_ACK_TAIL:  if (elapsed(low_ticks)) begin
                case (stage)
                    SG_ADDR_W: begin
                        stage   = SG_REG;
                        shifter = reg_sel;
                        go(BP_BIT_SETUP);
                    end
                    SG_REG: begin
                        if (rd_mode) begin
                            stage = SG_ADDR_R;
                            go(BP_RESTART);
                        end else begin
                            stage = SG_DATA;
                            go(BP_WAIT_BYTE);
                        end
                    end
                    SG_DATA: begin
                        bytes_left--;
                        if (bytes_left == 8'd0) begin_stop(ST_OK);
                        else go(BP_WAIT_BYTE);
                    end
                    default: begin
                        shifter = '0;
                        bit_idx = 0;
                        go(BP_RD_LOW);
                    end
                endcase
            end
            BP_WAIT_BYTE: if (hold_valid) begin
                shifter    = hold_byte;
                hold_valid = 1'b0;
                bit_idx    = 0;
                go(BP_BIT_SETUP);
            end
            BP_RD_LOW:    if (elapsed(low_ticks)) go(BP_RD_HIGH);
            BP_RD_HIGH:   if (elapsed(high_ticks)) begin
                shifter = {shifter[6:0], sda};
                bit_idx++;
                if (bit_idx >= 8) begin
                    bit_idx    = 0;
                    r.rx_valid = 1'b1;
                    r.rx_data  = shifter;
                    r.rx_last  = (bytes_left <= 8'd1);
                    go(BP_MACK_SETUP);
                end else begin
                    go(BP_RD_LOW);
                end
            end
            BP_MACK_SETUP: if (elapsed(low_ticks)) go(BP_MACK_HIGH);
            BP_MACK_HIGH:  if (elapsed(high_ticks)) go(BP_MACK_HOLD);
            BP_MACK_HOLD:  if (elapsed(low_ticks)) begin
                if (bytes_left <= 8'd1) begin
                    bytes_left = '0;
                    begin_stop(ST_OK);
                end else begin
                    bytes_left--;
                    shifter = '0;
                    go(BP_RD_LOW);
                end
            end
            BP_STOP_A: if (elapsed(low_ticks)) go(BP_STOP_B);
            BP_STOP_B: if (elapsed(low_ticks)) go(BP_STOP_C);
            BP_STOP_C: if (elapsed(high_ticks)) go(BP_STOP_D);
            BP_STOP_D: if (elapsed(high_ticks)) begin
                r.done   = 1'b1;
                r.status = end_code;
                end_code = ST_OK;
                go(BP_IDLE);
            end
            default: go(BP_IDLE);
        endcase
    endfunction

    // Apply an accepted request and queue the result it must produce
    function void note_request(t_cmd c);
        t_line_result r;
        r = '0;
        case (c.kind)
            CMD_START: if (phase == BP_IDLE) begin
                rd_mode    = c.read_mode;
                dev        = c.target_addr;
                reg_sel    = c.reg_addr;
                bytes_left = (c.byte_count == 8'd0) ? 8'd1 : c.byte_count;
                hold_valid = 1'b0;
                bit_idx    = 0;
                end_code   = ST_OK;
                stage      = SG_ADDR_W;
                go(BP_START_HI);
            end
            CMD_BYTE: begin
                hold_valid = 1'b1;
                hold_byte  = c.data_byte;
            end
            CMD_TICK: tick(c.sda, r);
            default: ;
        endcase

        // Line levels follow the phase reached
        case (phase)
            BP_IDLE, BP_START_HI, BP_ACK_HIGH, BP_ACK_WAIT, BP_RD_HIGH, BP_STOP_D: begin
                r.scl = 1'b1;
                r.sda = 1'b1;
            end
            BP_START_SDA, BP_STOP_C: begin
                r.scl = 1'b1;
                r.sda = 1'b0;
            end
            BP_START_SCL, BP_STOP_B: begin
                r.scl = 1'b0;
                r.sda = 1'b0;
            end
            BP_BIT_SETUP, BP_BIT_HOLD: begin
                r.scl = 1'b0;
                r.sda = shifter[7];
            end
            BP_BIT_HIGH: begin
                r.scl = 1'b1;
                r.sda = shifter[7];
            end
            BP_MACK_SETUP, BP_MACK_HOLD: begin
                r.scl = 1'b0;
                r.sda = (bytes_left <= 8'd1);
            end
            BP_MACK_HIGH: begin
                r.scl = 1'b1;
                r.sda = (bytes_left <= 8'd1);
            end
            default: begin
                r.scl = 1'b0;
                r.sda = 1'b1;
            end
        endcase
        r.busy      = (phase != BP_IDLE);
        r.need_byte = (phase == BP_WAIT_BYTE) && !hold_valid;
        expected_lines.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_lines(t_line_result got);
        t_line_result want;
        if (expected_lines.size() == 0) begin
            $error("result with no request outstanding");
            failures++;
            return;
        end
        want = expected_lines.pop_front();
        compare_field("scl_level", 8'(want.scl), 8'(got.scl));
        compare_field("sda_level", 8'(want.sda), 8'(got.sda));
        compare_field("busy_res", 8'(want.busy), 8'(got.busy));
        compare_field("need_byte", 8'(want.need_byte), 8'(got.need_byte));
        compare_field("rx_data", want.rx_data, got.rx_data);
        compare_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
        compare_field("rx_last", 8'(want.rx_last), 8'(got.rx_last));
        compare_field("done_res", 8'(want.done), 8'(got.done));
        compare_field("status", 8'(want.status), 8'(got.status));
    endfunction
endclass

module tb;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned RANDOM_ITEMS   = 1900;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    i2cm_req_if req_ch ();
    i2cm_res_if res_ch ();

    i2c_master_register_access_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    i2c_line_predictor bus = new();
    int unsigned counted_items;
    int unsigned req_burst;
    int unsigned res_burst;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, now and then a run with none
    function automatic int unsigned pick_gap(inout int unsigned burst_left);
        int unsigned roll;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_cmd random_request();
        t_cmd c;
        c.kind        = t_cmd_kind'($urandom_range(0, 3));
        c.sda         = 1'($urandom);
        c.read_mode   = 1'($urandom);
        c.target_addr = 7'($urandom);
        c.reg_addr    = 8'($urandom);
        c.byte_count  = 8'($urandom);
        c.data_byte   = 8'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] pick_phase_ticks();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return 8'd0;
        if (roll < 45) return 8'd1;
        if (roll < 75) return 8'd2;
        if (roll < 95) return 8'd3;
        return 8'($urandom_range(4, 8));
    endfunction

    function automatic logic [15:0] pick_ack_ticks();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 16'd0;
        if (roll < 70) return 16'($urandom_range(1, 3));
        if (roll < 90) return 16'd8;
        return 16'd25;
    endfunction

    // Present one request, hold it until taken, then idle for a random gap, which may be none
    task automatic send_request(input t_cmd c);
        int unsigned gap;
        counted_items++;
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= c.kind;
        req_ch.sda_in      <= c.sda;
        req_ch.read_mode   <= c.read_mode;
        req_ch.target_addr <= c.target_addr;
        req_ch.reg_addr    <= c.reg_addr;
        req_ch.byte_count  <= c.byte_count;
        req_ch.data_byte   <= c.data_byte;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        bus.note_request(c);
        gap = pick_gap(req_burst);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off requests until every result is back and the block is quiet
    task automatic settle_bus();
        req_ch.valid <= 1'b0;
        while (bus.expected_lines.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] low_t, input logic [7:0] high_t,
                                input logic [15:0] ack_t);
        logic [15:0] low_word;
        logic [15:0] high_word;
        // upper bits of the narrow registers are don't-care, so fill them with random bits
        low_word  = {8'($urandom), low_t};
        high_word = {8'($urandom), high_t};
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LOW;
        i_cfg_data <= low_word;
        @(posedge i_clk);
        bus.write_register(CFG_LOW, low_word);
        i_cfg_idx  <= CFG_HIGH;
        i_cfg_data <= high_word;
        @(posedge i_clk);
        bus.write_register(CFG_HIGH, high_word);
        i_cfg_idx  <= CFG_ACK;
        i_cfg_data <= ack_t;
        @(posedge i_clk);
        bus.write_register(CFG_ACK, ack_t);
        i_cfg_we <= 1'b0;
    endtask

    // Run one transaction to its stop, acting as the slave on SDA
    task automatic run_transfer(input logic rd, input logic [6:0] dev, input logic [7:0] ra,
                                input logic [7:0] cnt, input bit nack_on,
                                input t_byte_stage nack_at, input int unsigned noise_pct);
        t_cmd c;
        int unsigned ack_delay;
        ack_delay = $urandom_range(0, 2);
        // stray byte ahead of the start gets discarded
        if ($urandom_range(0, 9) == 0) begin
            c = random_request();
            c.kind = CMD_BYTE;
            send_request(c);
        end
        c = random_request();
        c.kind        = CMD_START;
        c.read_mode   = rd;
        c.target_addr = dev;
        c.reg_addr    = ra;
        c.byte_count  = cnt;
        send_request(c);
        while (bus.phase != BP_IDLE) begin
            c = random_request();
            if ($urandom_range(0, 99) >= noise_pct) begin
                if (bus.phase == BP_WAIT_BYTE && !bus.hold_valid) begin
                    c.kind = CMD_BYTE;
                end else begin
                    c.kind = CMD_TICK;
                    if (bus.phase == BP_ACK_WAIT)
                        c.sda = (nack_on && bus.stage == nack_at) || (bus.timer < ack_delay);
                end
            end
            send_request(c);
        end
    endtask

    // Take results with random stalls
    initial begin : result_sink
        int unsigned run;
        int unsigned stall;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            stall = pick_gap(res_burst);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Check every result taken
    always @(posedge i_clk) begin : result_monitor
        t_line_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = {res_ch.scl_level, res_ch.sda_level, res_ch.busy_res, res_ch.need_byte,
                   res_ch.rx_data, res_ch.rx_valid, res_ch.rx_last, res_ch.done_res,
                   res_ch.status};
            bus.check_lines(got);
        end
    end

    // Drop the run if no request or result moves for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        t_cmd          c;
        logic          rd;
        logic [7:0]    cnt;
        bit            nack_on;
        t_byte_stage   nack_at;
        int unsigned   roll;

        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_LOW;
        i_cfg_data         = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = CMD_TICK;
        req_ch.sda_in      = 1'b1;
        req_ch.read_mode   = 1'b0;
        req_ch.target_addr = '0;
        req_ch.reg_addr    = '0;
        req_ch.byte_count  = '0;
        req_ch.data_byte   = '0;
        counted_items      = 0;
        req_burst          = 0;
        res_burst          = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle bus: ticks, reserved code, a byte that the next start drops
        c = random_request();
        c.kind = CMD_TICK;
        c.sda  = 1'b0;
        send_request(c);
        c.sda  = 1'b1;
        send_request(c);
        c.kind = CMD_NONE;
        send_request(c);
        c.kind      = CMD_BYTE;
        c.data_byte = 8'hFF;
        send_request(c);

        // Reset timing, top addresses, zero byte count
        run_transfer(1'b0, 7'h7F, 8'hFF, 8'd0, 1'b0, SG_ADDR_W, 0);

        // Zero phase lengths, then every end code
        settle_bus();
        write_config(8'd0, 8'd0, 16'd4);
        run_transfer(1'b1, 7'h00, 8'h00, 8'd1, 1'b0, SG_ADDR_W, 0);
        run_transfer(1'b1, 7'h55, 8'hAA, 8'd3, 1'b0, SG_ADDR_W, 0);
        run_transfer(1'b0, 7'h2A, 8'h55, 8'd255, 1'b1, SG_ADDR_W, 0);
        run_transfer(1'b1, 7'h33, 8'h0F, 8'd2, 1'b1, SG_REG, 0);
        run_transfer(1'b0, 7'h4C, 8'hF0, 8'd3, 1'b1, SG_DATA, 0);
        run_transfer(1'b1, 7'h19, 8'h81, 8'd2, 1'b1, SG_ADDR_R, 0);
        // starts while busy, early and overwritten bytes, reserved codes
        run_transfer(1'b0, 7'h66, 8'h3C, 8'd4, 1'b0, SG_ADDR_W, 30);

        // Longer phases, address timed out
        settle_bus();
        write_config(8'd9, 8'd12, 16'd40);
        run_transfer(1'b0, 7'($urandom), 8'($urandom), 8'd1, 1'b1, SG_ADDR_W, 0);

        // Random phases of timing settings and transactions
        while (counted_items < RANDOM_ITEMS) begin
            settle_bus();
            write_config(pick_phase_ticks(), pick_phase_ticks(), pick_ack_ticks());
            repeat ($urandom_range(2, 6)) begin
                if (counted_items >= RANDOM_ITEMS) break;
                if ($urandom_range(0, 3) == 0) begin
                    c = random_request();
                    if (c.kind == CMD_START) c.kind = CMD_NONE;
                    send_request(c);
                end
                rd   = 1'($urandom);
                roll = $urandom_range(0, 99);
                if (roll < 5) cnt = 8'd0;
                else cnt = 8'($urandom_range(1, 4));
                nack_on = ($urandom_range(0, 99) < 15);
                case ($urandom_range(0, 2))
                    0:       nack_at = SG_ADDR_W;
                    1:       nack_at = SG_REG;
                    default: nack_at = rd ? SG_ADDR_R : SG_DATA;
                endcase
                run_transfer(rd, 7'($urandom), 8'($urandom), cnt, nack_on, nack_at, 5);
            end
        end

        settle_bus();
        if (bus.failures == 0 && bus.expected_lines.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
